@@ hw/rtl/lpt_pkg.sv @@
// Shared types and constants for the looping playback position timer.
`default_nettype none

package lpt_pkg;

  // Default widths
  localparam int TIME_BITS_DEF      = 48;
  localparam int RATE_FRAC_BITS_DEF = 16;

  // Fixed field widths
  localparam int RATE_W    = 24;
  localparam int PLAY_W    = 32;
  localparam int CFG_IDX_W = 3;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RATE    = 3'd0,
    CFG_START   = 3'd1,
    CFG_END     = 3'd2,
    CFG_LIMIT   = 3'd3,
    CFG_FOREVER = 3'd4
  } lpt_cfg_idx_t;

  // Item modes
  typedef enum logic [1:0] {
    MODE_TICK    = 2'd0,
    MODE_SET     = 2'd1,
    MODE_RESTART = 2'd2
  } lpt_mode_t;

  // Shared shift/add unit operations
  typedef enum logic [2:0] {
    LPT_OP_HOLD     = 3'd0,
    LPT_OP_CLEAR    = 3'd1,
    LPT_OP_MUL      = 3'd2,
    LPT_OP_DIV_LOAD = 3'd3,
    LPT_OP_DIV      = 3'd4
  } lpt_op_t;

  typedef struct packed {
    lpt_op_t op;
    logic    mul_bit;
  } lpt_cmd_t;

endpackage

`default_nettype wire

@@ hw/rtl/lpt_shift_unit.sv @@
// Shared shift/add unit: bit-serial multiply and restoring divide on one adder.
`default_nettype none

module lpt_shift_unit #(
  parameter int TIME_BITS = lpt_pkg::TIME_BITS_DEF
) (
  input  wire logic                                  clk,
  input  wire lpt_pkg::lpt_cmd_t                     cmd,
  input  wire logic [TIME_BITS-1:0]                  addend,
  input  wire logic [TIME_BITS-1:0]                  divisor,
  output logic      [TIME_BITS+lpt_pkg::RATE_W-1:0]  product,
  output logic      [TIME_BITS-1:0]                  quotient,
  output logic      [TIME_BITS-1:0]                  remainder
);

  localparam int PW = TIME_BITS + lpt_pkg::RATE_W;

  logic [PW-1:0]        hi_r;
  logic [TIME_BITS-1:0] lo_r;
  logic [TIME_BITS:0]   rs;
  logic [PW-1:0]        op_a;
  logic [PW-1:0]        op_b;
  logic                 cin;
  logic [PW-1:0]        sum;
  logic                 fits;

  // Partial remainder shifted left by one, next dividend bit in
  assign rs = {hi_r[TIME_BITS-1:0], lo_r[TIME_BITS-1]};

  always_comb begin
    op_a = '0;
    op_b = '0;
    cin  = 1'b0;
    case (cmd.op)
      lpt_pkg::LPT_OP_MUL: begin
        op_a = {hi_r[PW-2:0], 1'b0};
        op_b = cmd.mul_bit ? PW'(addend) : '0;
      end
      lpt_pkg::LPT_OP_DIV: begin
        op_a = PW'(rs);
        op_b = ~PW'(divisor);
        cin  = 1'b1;
      end
      default: begin
        op_a = '0;
      end
    endcase
  end

  assign sum  = op_a + op_b + PW'(cin);
  // Operands are far below 2^(PW-1), so the top bit flags a borrow
  assign fits = ~sum[PW-1];

  always_ff @(posedge clk) begin
    case (cmd.op)
      lpt_pkg::LPT_OP_CLEAR: begin
        hi_r <= '0;
      end
      lpt_pkg::LPT_OP_MUL: begin
        hi_r <= sum;
      end
      lpt_pkg::LPT_OP_DIV_LOAD: begin
        hi_r <= '0;
        lo_r <= addend;
      end
      lpt_pkg::LPT_OP_DIV: begin
        hi_r <= fits ? sum : PW'(rs);
        lo_r <= {lo_r[TIME_BITS-2:0], fits};
      end
      default: begin
        hi_r <= hi_r;
      end
    endcase
  end

  assign product   = hi_r;
  assign quotient  = lo_r;
  assign remainder = hi_r[TIME_BITS-1:0];

endmodule

`default_nettype wire

@@ hw/rtl/looping_playback_position_timer_top.sv @@
// Top level of the looping playback position timer.
`default_nettype none

// Looping playback position timer. Each input beat carries a mode and an amount and
// produces exactly one result beat with the new position, the play count and a
// repeats-left flag. A tick (mode 0) scales the elapsed nanoseconds by the signed
// fixed-point rate and moves the position forward or backward inside the span
// [start_time, end_time]; crossing an end adds one play plus one per extra whole span
// and wraps by the remainder while repeats are left, else clamps at that end. Set
// (mode 1) loads the amount, clamped up to start_time; restart (mode 2) clears the
// play count and rewinds to start_time; mode 3 reports the state unchanged. The block
// works on one beat at a time: in_ready is high only while the sequencer is idle.
// A tick's cost is set by one shared adder that does the multiply one rate bit per
// cycle and the quotient/remainder division one bit per cycle. The result sits in an
// output register, so a new beat can be accepted while the last result still waits
// for out_ready. Configuration writes take effect at once and are only to be issued
// while no beat is in flight.

module looping_playback_position_timer_top #(
  parameter int TIME_BITS      = lpt_pkg::TIME_BITS_DEF,
  parameter int RATE_FRAC_BITS = lpt_pkg::RATE_FRAC_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // Configuration write port
  input  wire logic                           cfg_we,
  input  wire logic [lpt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [TIME_BITS-1:0]           cfg_wdata,
  // Input channel
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [1:0]                     in_mode,
  input  wire logic [TIME_BITS-1:0]           in_amount,
  // Result channel
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic      [TIME_BITS-1:0]           out_position,
  output logic      [lpt_pkg::PLAY_W-1:0]     out_plays_done,
  output logic                                out_repeats_left
);

  localparam int RW    = lpt_pkg::RATE_W;
  localparam int PW    = TIME_BITS + RW;
  localparam int PLW   = lpt_pkg::PLAY_W;
  localparam int CNT_W = $clog2(TIME_BITS);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL,
    ST_SCALE,
    ST_DIST,
    ST_CROSS,
    ST_STEP,
    ST_DIV,
    ST_PLAY,
    ST_WRAP,
    ST_FIN
  } state_t;

  // Configuration registers
  logic [RW-1:0]        rate_r;
  logic [TIME_BITS-1:0] start_r;
  logic [TIME_BITS-1:0] end_r;
  logic [PLW-1:0]       limit_r;
  logic                 forever_r;

  // Sequencer and working registers
  state_t               state_r;
  logic [TIME_BITS-1:0] amt_r;
  logic                 neg_r;
  logic [RW-1:0]        mag_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [TIME_BITS-1:0] span_r;
  logic [TIME_BITS-1:0] scaled_r;
  logic [TIME_BITS-1:0] dist_r;
  logic                 past_r;
  logic [TIME_BITS-1:0] next_r;
  logic                 clamp_r;

  // Architectural state
  logic [TIME_BITS-1:0] pos_r;
  logic [PLW-1:0]       pc_r;

  // Result register
  logic                 out_valid_r;
  logic [TIME_BITS-1:0] out_position_r;
  logic [PLW-1:0]       out_plays_r;
  logic                 out_rep_r;

  // Shared unit hookup
  lpt_pkg::lpt_cmd_t    cmd;
  logic [TIME_BITS-1:0] unit_addend;
  logic [PW-1:0]        product;
  logic [TIME_BITS-1:0] quotient;
  logic [TIME_BITS-1:0] remainder;

  // Combinational helpers
  logic                 in_fire;
  logic                 out_free;
  logic                 has_rep_w;
  logic                 empty_w;
  logic [RW-1:0]        mag_w;
  logic [PW:0]          prod_x;
  logic [TIME_BITS-1:0] scaled_w;
  logic [TIME_BITS:0]   diff_w;
  logic [TIME_BITS:0]   sum_w;
  logic [TIME_BITS-1:0] excess_w;
  logic                 over_w;
  logic                 q_big;
  logic [PLW+1:0]       psum;
  logic [PLW-1:0]       pc_nxt;
  logic                 rep_after_w;
  logic [TIME_BITS-1:0] pos_fin;
  logic                 fin_rep_w;

  assign in_fire  = in_valid & in_ready;
  assign in_ready = (state_r == ST_IDLE);
  assign out_free = ~out_valid_r | out_ready;

  assign has_rep_w = forever_r | (pc_r < limit_r);
  assign empty_w   = (end_r <= start_r);
  // Magnitude of the two's complement rate
  assign mag_w     = rate_r[RW-1] ? (~rate_r + RW'(1)) : rate_r;

  // Drop the fraction bits and saturate to the all-ones time value
  assign prod_x   = {1'b0, product};
  assign scaled_w = (|prod_x[PW:TIME_BITS+RATE_FRAC_BITS]) ? '1 :
                    prod_x[TIME_BITS+RATE_FRAC_BITS-1:RATE_FRAC_BITS];

  // Overshoot past the end being approached
  assign diff_w = {1'b0, scaled_r} - {1'b0, dist_r};
  assign sum_w  = {1'b0, dist_r} + {1'b0, scaled_r};

  always_comb begin
    if (~neg_r && past_r) begin
      excess_w = sum_w[TIME_BITS] ? '1 : sum_w[TIME_BITS-1:0];
      over_w   = (excess_w != '0);
    end else begin
      excess_w = diff_w[TIME_BITS-1:0];
      over_w   = ~diff_w[TIME_BITS] && (diff_w[TIME_BITS-1:0] != '0);
    end
  end

  // Play count update: one plus the number of extra whole spans, saturating
  assign q_big       = |(quotient >> PLW);
  assign psum        = {2'b00, pc_r} + (PLW+2)'(1) + {2'b00, quotient[PLW-1:0]};
  assign pc_nxt      = (q_big || (|psum[PLW+1:PLW])) ? '1 : psum[PLW-1:0];
  assign rep_after_w = forever_r | (pc_nxt < limit_r);

  // Final position, clamped up to start where the operation calls for it
  assign pos_fin   = (clamp_r && (next_r < start_r)) ? start_r : next_r;
  assign fin_rep_w = has_rep_w;

  // Shared unit command
  always_comb begin
    cmd.op      = lpt_pkg::LPT_OP_HOLD;
    cmd.mul_bit = mag_r[RW-1];
    case (state_r)
      ST_PREP: begin
        if (!empty_w) begin
          cmd.op = lpt_pkg::LPT_OP_CLEAR;
        end
      end
      ST_MUL: begin
        cmd.op = lpt_pkg::LPT_OP_MUL;
      end
      ST_CROSS: begin
        if (over_w && has_rep_w) begin
          cmd.op = lpt_pkg::LPT_OP_DIV_LOAD;
        end
      end
      ST_DIV: begin
        cmd.op = lpt_pkg::LPT_OP_DIV;
      end
      default: begin
        cmd.op = lpt_pkg::LPT_OP_HOLD;
      end
    endcase
  end

  assign unit_addend = (state_r == ST_CROSS) ? excess_w : amt_r;

  lpt_shift_unit #(
    .TIME_BITS (TIME_BITS)
  ) u_shift_unit (
    .clk       (clk),
    .cmd       (cmd),
    .addend    (unit_addend),
    .divisor   (span_r),
    .product   (product),
    .quotient  (quotient),
    .remainder (remainder)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r    <= RW'(1) << RATE_FRAC_BITS;
      start_r   <= '0;
      end_r     <= '0;
      limit_r   <= PLW'(1);
      forever_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        lpt_pkg::CFG_RATE:    rate_r    <= cfg_wdata[RW-1:0];
        lpt_pkg::CFG_START:   start_r   <= cfg_wdata;
        lpt_pkg::CFG_END:     end_r     <= cfg_wdata;
        lpt_pkg::CFG_LIMIT:   limit_r   <= cfg_wdata[PLW-1:0];
        lpt_pkg::CFG_FOREVER: forever_r <= cfg_wdata[0];
        default: begin
          forever_r <= forever_r;
        end
      endcase
    end
  end

  // Sequencer, state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= '0;
      pc_r        <= '0;
      out_valid_r <= 1'b0;
      clamp_r     <= 1'b0;
    end else begin
      // Load a new result when one is ready, else drop valid once taken
      if ((state_r == ST_FIN) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            amt_r <= in_amount;
            case (in_mode)
              lpt_pkg::MODE_TICK: begin
                state_r <= ST_PREP;
              end
              lpt_pkg::MODE_SET: begin
                next_r  <= in_amount;
                clamp_r <= 1'b1;
                state_r <= ST_FIN;
              end
              lpt_pkg::MODE_RESTART: begin
                pc_r    <= '0;
                next_r  <= start_r;
                clamp_r <= 1'b1;
                state_r <= ST_FIN;
              end
              default: begin
                // Unused mode: report the state as it is
                next_r  <= pos_r;
                clamp_r <= 1'b0;
                state_r <= ST_FIN;
              end
            endcase
          end
        end
        ST_PREP: begin
          if (empty_w) begin
            next_r  <= pos_r;
            clamp_r <= 1'b0;
            state_r <= ST_FIN;
          end else begin
            span_r  <= end_r - start_r;
            neg_r   <= rate_r[RW-1];
            mag_r   <= mag_w;
            cnt_r   <= CNT_W'(RW - 1);
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          mag_r <= {mag_r[RW-2:0], 1'b0};
          cnt_r <= cnt_r - CNT_W'(1);
          if (cnt_r == '0) begin
            state_r <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          scaled_r <= scaled_w;
          state_r  <= ST_DIST;
        end
        ST_DIST: begin
          // Distance to the end being approached
          if (neg_r) begin
            past_r <= 1'b0;
            dist_r <= (pos_r > start_r) ? (pos_r - start_r) : '0;
          end else if (pos_r >= end_r) begin
            past_r <= 1'b1;
            dist_r <= pos_r - end_r;
          end else begin
            past_r <= 1'b0;
            dist_r <= end_r - pos_r;
          end
          state_r <= ST_CROSS;
        end
        ST_CROSS: begin
          clamp_r <= 1'b1;
          if (!over_w) begin
            state_r <= ST_STEP;
          end else begin
            next_r <= neg_r ? start_r : end_r;
            if (has_rep_w) begin
              cnt_r   <= CNT_W'(TIME_BITS - 1);
              state_r <= ST_DIV;
            end else begin
              state_r <= ST_FIN;
            end
          end
        end
        ST_STEP: begin
          next_r  <= neg_r ? (pos_r - scaled_r) : (pos_r + scaled_r);
          state_r <= ST_FIN;
        end
        ST_DIV: begin
          cnt_r <= cnt_r - CNT_W'(1);
          if (cnt_r == '0) begin
            state_r <= ST_PLAY;
          end
        end
        ST_PLAY: begin
          pc_r    <= pc_nxt;
          state_r <= rep_after_w ? ST_WRAP : ST_FIN;
        end
        ST_WRAP: begin
          // Wrap by the remainder from the opposite end
          next_r  <= neg_r ? (end_r - remainder) : (start_r + remainder);
          state_r <= ST_FIN;
        end
        ST_FIN: begin
          // Hold until the result register is free
          if (out_free) begin
            pos_r          <= pos_fin;
            out_position_r <= pos_fin;
            out_plays_r    <= pc_r;
            out_rep_r      <= fin_rep_w;
            state_r        <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_position     = out_position_r;
  assign out_plays_done   = out_plays_r;
  assign out_repeats_left = out_rep_r;

  // A clamped result never lands below start
  a_clamp_floor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN) && out_free && clamp_r |=> (pos_r >= start_r))
    else $error("position below start after clamped update");

  // Divider remainder stays inside the span
  a_rem_in_span: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WRAP) |-> (remainder < span_r))
    else $error("division remainder not below span");

  // Play count only drops on a restart beat
  a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r < $past(pc_r)) |-> $past(in_fire && (in_mode == lpt_pkg::MODE_RESTART)))
    else $error("play count decreased without restart");

  // No second beat is taken while one is in flight
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ready)
    else $error("input accepted while busy");

endmodule

`default_nettype wire
